### hdl/hwf_pkg.sv
`default_nettype none

package hwf_pkg;

	localparam int OP_W    = 2;
	localparam int COORD_W = 6;
	localparam int VAL_W   = 32;
	localparam int TOL_W   = 16;
	localparam int LVL_W   = VAL_W + 1;

	typedef enum logic [OP_W-1:0] {
		OP_WRITE = 2'd0,
		OP_PASS  = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	localparam logic CFG_SOIL = 1'b0;
	localparam logic CFG_TOL  = 1'b1;

	localparam logic [TOL_W-1:0] TOL_RESET = 16'd7;

	// controller to datapath
	typedef struct packed {
		logic host_wr;   // water write data comes from the input beat
		logic wr_b;      // write back cell b of the pair, else cell a
		logic out_load;  // load the result register
		logic out_read;  // result carries the cell read
		logic out_pass;  // result flags a finished pass
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

### hdl/hwf_ram.sv
`default_nettype none

module hwf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr_a,
	input  wire logic [AW-1:0]    raddr_b,
	output logic      [WIDTH-1:0] rdata_a,
	output logic      [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

`default_nettype wire

### hdl/hwf_dp.sv
`default_nettype none

module hwf_dp
	import hwf_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire dp_cmd_t          cmd,
	output dp_stat_t              stat,
	input  wire logic [VAL_W-1:0] in_water,
	input  wire logic [VAL_W-1:0] soil,
	input  wire logic [TOL_W-1:0] tol,
	input  wire logic [VAL_W-1:0] rd_h_a,
	input  wire logic [VAL_W-1:0] rd_h_b,
	input  wire logic [VAL_W-1:0] rd_w_a,
	input  wire logic [VAL_W-1:0] rd_w_b,
	output logic      [VAL_W-1:0] wr_water,
	input  wire logic             out_ready,
	output logic                  out_valid,
	output logic      [VAL_W-1:0] water_value,
	output logic      [VAL_W-1:0] height_value,
	output logic                  pass_done
);

	// stage 1: levels
	logic [LVL_W-1:0] la_s1, lb_s1;
	logic [VAL_W-1:0] wa_s1, wb_s1;
	// stage 2: difference and direction
	logic [LVL_W-1:0] diff_s2;
	logic             a_src_s2;
	logic [VAL_W-1:0] ws_s2, wd_s2;
	// stage 3: limits
	logic             ok_s3, a_src_s3;
	logic [VAL_W-1:0] half_s3, spare_s_s3, spare_d_s3, ws_s3, wd_s3;
	// stage 4: amount
	logic [VAL_W-1:0] amt_s4, ws_s4, wd_s4;
	logic             a_src_s4;

	logic [VAL_W-1:0] m1, amt, new_src, new_dst, new_a, new_b;
	logic             a_hi;

	assign a_hi = la_s1 > lb_s1;
	assign m1   = (half_s3 < spare_s_s3) ? half_s3 : spare_s_s3;
	assign amt  = (spare_d_s3 < m1) ? spare_d_s3 : m1;

	// registered reads hold between pairs, so the stages settle and stay put
	always_ff @(posedge clk) begin
		la_s1 <= {1'b0, rd_h_a} + {1'b0, rd_w_a};
		lb_s1 <= {1'b0, rd_h_b} + {1'b0, rd_w_b};
		wa_s1 <= rd_w_a;
		wb_s1 <= rd_w_b;

		a_src_s2 <= a_hi;
		diff_s2  <= a_hi ? (la_s1 - lb_s1) : (lb_s1 - la_s1);
		ws_s2    <= a_hi ? wa_s1 : wb_s1;
		wd_s2    <= a_hi ? wb_s1 : wa_s1;

		ok_s3      <= (diff_s2 != '0) && (diff_s2 >= LVL_W'(tol)) && (ws_s2 > soil);
		half_s3    <= diff_s2[LVL_W-1:1];
		spare_s_s3 <= ws_s2 - soil;
		spare_d_s3 <= ~wd_s2;
		ws_s3      <= ws_s2;
		wd_s3      <= wd_s2;
		a_src_s3   <= a_src_s2;

		amt_s4   <= ok_s3 ? amt : '0;
		ws_s4    <= ws_s3;
		wd_s4    <= wd_s3;
		a_src_s4 <= a_src_s3;
	end

	assign new_src = ws_s4 - amt_s4;
	assign new_dst = wd_s4 + amt_s4;
	assign new_a   = a_src_s4 ? new_src : new_dst;
	assign new_b   = a_src_s4 ? new_dst : new_src;

	always_comb begin
		if (cmd.host_wr) begin
			wr_water = in_water;
		end else if (cmd.wr_b) begin
			wr_water = new_b;
		end else begin
			wr_water = new_a;
		end
	end

	// result register
	assign stat.out_free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			water_value  <= cmd.out_read ? rd_w_a : '0;
			height_value <= cmd.out_read ? rd_h_a : '0;
			pass_done    <= cmd.out_pass;
		end
	end

endmodule

`default_nettype wire

### hdl/hwf_ctrl.sv
`default_nettype none

module hwf_ctrl
	import hwf_pkg::*;
#(
	parameter int ROWS = 64,
	parameter int COLS = 64,
	localparam int RW = $clog2(ROWS),
	localparam int CW = $clog2(COLS),
	localparam int AW = RW + CW
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire op_t                op,
	input  wire logic [COORD_W-1:0] row,
	input  wire logic [COORD_W-1:0] col,
	output dp_cmd_t                 cmd,
	input  wire dp_stat_t           stat,
	output logic                    re,
	output logic [AW-1:0]           raddr_a,
	output logic [AW-1:0]           raddr_b,
	output logic                    we_h,
	output logic                    we_w,
	output logic [AW-1:0]           waddr
);

	localparam int RXW = (RW > COORD_W) ? RW : COORD_W;
	localparam int CXW = (CW > COORD_W) ? CW : COORD_W;

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_PRD  = 9'b000000010,
		S_PL1  = 9'b000000100,
		S_PL2  = 9'b000001000,
		S_PL3  = 9'b000010000,
		S_PL4  = 9'b000100000,
		S_PWA  = 9'b001000000,
		S_PWB  = 9'b010000000,
		S_DONE = 9'b100000000
	} state_t;

	state_t        state_q, state_d;
	logic [RW-1:0] r_q;
	logic [CW-1:0] c_q;
	logic          sweep_q;
	logic          read_q, pass_q;

	logic [RXW-1:0] row_x;
	logic [CXW-1:0] col_x;
	logic [AW-1:0]  host_a, pair_a, pair_b;
	logic           in_grid, accept, last_pair;

	assign row_x   = RXW'(row);
	assign col_x   = CXW'(col);
	assign host_a  = {row_x[RW-1:0], col_x[CW-1:0]};
	assign in_grid = (32'(row) < 32'(ROWS)) && (32'(col) < 32'(COLS));

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	assign pair_a = {r_q, c_q};
	assign pair_b = sweep_q ? {r_q, c_q + 1'b1} : {r_q + 1'b1, c_q};

	assign last_pair = sweep_q && (c_q == CW'(COLS - 2)) && (r_q == RW'(ROWS - 1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = (op == OP_PASS) ? S_PRD : S_DONE;
				end
			end
			S_PRD:  state_d = S_PL1;
			S_PL1:  state_d = S_PL2;
			S_PL2:  state_d = S_PL3;
			S_PL3:  state_d = S_PL4;
			S_PL4:  state_d = S_PWA;
			S_PWA:  state_d = S_PWB;
			S_PWB:  state_d = last_pair ? S_DONE : S_PRD;
			S_DONE: begin
				if (stat.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			r_q     <= '0;
			c_q     <= '0;
			sweep_q <= 1'b0;
			read_q  <= 1'b0;
			pass_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				read_q  <= (op == OP_READ) && in_grid;
				pass_q  <= (op == OP_PASS);
				r_q     <= '0;
				c_q     <= '0;
				sweep_q <= 1'b0;
			end else if (state_q == S_PWB && !last_pair) begin
				if (!sweep_q) begin
					// vertical pairs: column inner
					if (c_q == CW'(COLS - 1)) begin
						c_q <= '0;
						if (r_q == RW'(ROWS - 2)) begin
							r_q     <= '0;
							sweep_q <= 1'b1;
						end else begin
							r_q <= r_q + 1'b1;
						end
					end else begin
						c_q <= c_q + 1'b1;
					end
				end else begin
					// horizontal pairs: row inner
					if (r_q == RW'(ROWS - 1)) begin
						r_q <= '0;
						c_q <= c_q + 1'b1;
					end else begin
						r_q <= r_q + 1'b1;
					end
				end
			end
		end
	end

	// memory commands
	assign re      = (accept && (op == OP_READ)) || (state_q == S_PRD);
	assign raddr_a = (state_q == S_PRD) ? pair_a : host_a;
	assign raddr_b = pair_b;
	assign we_h    = accept && (op == OP_WRITE) && in_grid;
	assign we_w    = we_h || (state_q == S_PWA) || (state_q == S_PWB);
	assign waddr   = (state_q == S_PWA) ? pair_a : ((state_q == S_PWB) ? pair_b : host_a);

	assign cmd.host_wr  = (state_q == S_IDLE);
	assign cmd.wr_b     = (state_q == S_PWB);
	assign cmd.out_load = (state_q == S_DONE) && stat.out_free;
	assign cmd.out_read = read_q;
	assign cmd.out_pass = pass_q;

`ifndef SYNTH
	a_pwb_next: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PWB |=> state_q == S_PRD || state_q == S_DONE)
		else $error("pair write-back not followed by next read or done");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(r_q) <= 32'(ROWS - 1)) && (32'(c_q) <= 32'(COLS - 1)))
		else $error("sweep counters out of grid");

	a_vert_row: assert property (@(posedge clk) disable iff (!arst_n)
		!sweep_q |-> 32'(r_q) <= 32'(ROWS - 2))
		else $error("vertical sweep past next-to-last row");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> stat.out_free)
		else $error("result loaded over an untaken beat");

	a_no_rw: assert property (@(posedge clk) disable iff (!arst_n)
		!(we_w && re))
		else $error("read and write issued together");
`endif

endmodule

`default_nettype wire

### hdl/heightmap_water_flow_pass_top.sv
// Sequence: a write or read beat raises m_tvalid once the result register is free; a pass
// beat steps each neighbor pair through read (S_PRD), compute (S_PL1 to S_PL4) and write-back
// (S_PWA, S_PWB) through the single write port, over (ROWS-1)*COLS + ROWS*(COLS-1) pairs.
// Throughput: one beat in work at a time; the next beat is taken once a result waits.
// Reset (arst_n low, asynchronous): control and configuration return to reset
// values; cell memories hold nothing defined until written.
`default_nettype none

module heightmap_water_flow_pass_top
	import hwf_pkg::*;
#(
	parameter int ROWS = 64,
	parameter int COLS = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [79:0] s_tdata,   // row[5:0], col[11:6], height[43:12], water[75:44]
	input  wire logic [1:0]  s_tuser,   // operation[1:0]
	// result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata,   // water_value[31:0], height_value[63:32]
	output logic [0:0]       m_tuser,   // pass_done[0]
	// configuration writes
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_data
);

	localparam int RW    = $clog2(ROWS);
	localparam int CW    = $clog2(COLS);
	localparam int AW    = RW + CW;
	localparam int DEPTH = 1 << AW;

	// input beat fields
	logic [COORD_W-1:0] row, col;
	logic [VAL_W-1:0]   height, water;
	op_t                op;

	assign row    = s_tdata[5:0];
	assign col    = s_tdata[11:6];
	assign height = s_tdata[43:12];
	assign water  = s_tdata[75:44];
	assign op     = op_t'(s_tuser);

	// configuration registers
	logic [VAL_W-1:0] soil_q;
	logic [TOL_W-1:0] tol_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			soil_q <= '0;
			tol_q  <= TOL_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_SOIL: soil_q <= cfg_data;
				CFG_TOL:  tol_q  <= cfg_data[TOL_W-1:0];
				default:  soil_q <= soil_q;
			endcase
		end
	end

	// controller / datapath / cell memories
	dp_cmd_t          cmd;
	dp_stat_t         stat;
	logic             re, we_h, we_w;
	logic [AW-1:0]    raddr_a, raddr_b, waddr;
	logic [VAL_W-1:0] rd_h_a, rd_h_b, rd_w_a, rd_w_b, wr_water;
	logic [VAL_W-1:0] water_value, height_value;
	logic             pass_done;

	hwf_ctrl #(
		.ROWS (ROWS),
		.COLS (COLS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.op       (op),
		.row      (row),
		.col      (col),
		.cmd      (cmd),
		.stat     (stat),
		.re       (re),
		.raddr_a  (raddr_a),
		.raddr_b  (raddr_b),
		.we_h     (we_h),
		.we_w     (we_w),
		.waddr    (waddr)
	);

	// heights change only on host writes
	hwf_ram #(
		.WIDTH (VAL_W),
		.DEPTH (DEPTH)
	) u_height_ram (
		.clk     (clk),
		.we      (we_h),
		.waddr   (waddr),
		.wdata   (height),
		.re      (re),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rd_h_a),
		.rdata_b (rd_h_b)
	);

	// water is rewritten by host writes and by each pair of a pass
	hwf_ram #(
		.WIDTH (VAL_W),
		.DEPTH (DEPTH)
	) u_water_ram (
		.clk     (clk),
		.we      (we_w),
		.waddr   (waddr),
		.wdata   (wr_water),
		.re      (re),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rd_w_a),
		.rdata_b (rd_w_b)
	);

	hwf_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.in_water     (water),
		.soil         (soil_q),
		.tol          (tol_q),
		.rd_h_a       (rd_h_a),
		.rd_h_b       (rd_h_b),
		.rd_w_a       (rd_w_a),
		.rd_w_b       (rd_w_b),
		.wr_water     (wr_water),
		.out_ready    (m_tready),
		.out_valid    (m_tvalid),
		.water_value  (water_value),
		.height_value (height_value),
		.pass_done    (pass_done)
	);

	// pack the result beat
	assign m_tdata = {height_value, water_value};
	assign m_tuser = pass_done;

endmodule

`default_nettype wire
